### hw/rtl/pdf_pkg.sv
// types and constants shared by the particle drag force pipeline
`default_nettype none

package pdf_pkg;

    localparam int VEL_W   = 32;
    localparam int COEF_W  = 31;
    localparam int SQ_W    = 2 * VEL_W;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int QPROD_W = COEF_W + ROOT_W;
    localparam int FRAC_W  = 16;
    localparam int CEFF_W  = 48;
    localparam int HP_W    = (CEFF_W - VEL_W) + VEL_W;
    localparam int LP_W    = 2 * VEL_W;
    localparam int MAG_W   = CEFF_W + 1;
    localparam int LANES   = 3;

    localparam int SQRT_STEPS  = 2;
    localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

    localparam int ST_ABS     = 0;
    localparam int ST_SQ      = 1;
    localparam int ST_SUM     = 2;
    localparam int ST_ROOT0   = 3;
    localparam int ST_QPROD   = ST_ROOT0 + SQRT_STAGES;
    localparam int ST_COEFF   = ST_QPROD + 1;
    localparam int ST_PROD    = ST_COEFF + 1;
    localparam int ST_MAG     = ST_PROD + 1;
    localparam int ST_OUT     = ST_MAG + 1;
    localparam int NUM_STAGES = ST_OUT + 1;

    localparam int  ADDR_W        = 3;
    localparam int  DATA_W        = 32;
    localparam logic REG_LINEAR    = 1'b0;
    localparam logic REG_QUADRATIC = 1'b1;

    typedef struct packed {
        logic [SUM_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } root_state_t;

    typedef struct packed {
        logic [LANES-1:0][VEL_W-1:0] mag;
        logic [LANES-1:0]            neg;
    } vel_item_t;

    typedef struct packed {
        logic ld_prod;
        logic ld_mag;
        logic ld_out;
    } comp_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/pdf_root_stage.sv
// one pipeline stage of the integer square root, two root bits per stage
`default_nettype none

module pdf_root_stage (
    input  logic                  clk,
    input  logic                  load,
    input  pdf_pkg::root_state_t  din,
    output pdf_pkg::root_state_t  dout
);

    pdf_pkg::root_state_t state_reg;
    pdf_pkg::root_state_t state_next;
    logic [pdf_pkg::REM_W+1:0] cand;
    logic [pdf_pkg::REM_W+1:0] trial;

    always_comb
    begin
        state_next = din;
        cand       = '0;
        trial      = '0;
        for (int i = 0; i < pdf_pkg::SQRT_STEPS; i++)
        begin
            cand  = {state_next.rem, state_next.rad[pdf_pkg::SUM_W-1 -: 2]};
            trial = {2'b00, state_next.root, 2'b01};
            state_next.rad = {state_next.rad[pdf_pkg::SUM_W-3:0], 2'b00};
            if (cand >= trial)
            begin
                state_next.rem  = pdf_pkg::REM_W'(cand - trial);
                state_next.root = {state_next.root[pdf_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                state_next.rem  = pdf_pkg::REM_W'(cand);
                state_next.root = {state_next.root[pdf_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            state_reg <= state_next;
        end
    end

    assign dout = state_reg;

endmodule

`default_nettype wire

### hw/rtl/pdf_drag_comp.sv
// force component: coefficient times speed component, clipping and sign
`default_nettype none

module pdf_drag_comp (
    input  logic                         clk,
    input  pdf_pkg::comp_ctl_t           ctl,
    input  logic [pdf_pkg::CEFF_W-1:0]   coeff,
    input  logic [pdf_pkg::VEL_W-1:0]    mag,
    input  logic                         neg,
    output logic [pdf_pkg::VEL_W-1:0]    force_val,
    output logic                         sat
);

    localparam int HI_W = pdf_pkg::CEFF_W - pdf_pkg::VEL_W;

    // product stage
    logic [pdf_pkg::HP_W-1:0]  hp_reg, hp_next;
    logic [pdf_pkg::LP_W-1:0]  lp_reg, lp_next;
    logic                      neg_p_reg;

    // magnitude stage
    logic [pdf_pkg::MAG_W-1:0] mag_reg, mag_next;
    logic                      big_reg, big_next;
    logic                      neg_m_reg;

    // output stage
    logic [pdf_pkg::MAG_W-1:0] limit;
    logic                      clip;
    logic [pdf_pkg::VEL_W-1:0] clipped;
    logic [pdf_pkg::VEL_W-1:0] force_reg, force_next;
    logic                      sat_reg, sat_next;

    always_comb
    begin
        hp_next = pdf_pkg::HP_W'(coeff[pdf_pkg::CEFF_W-1:pdf_pkg::VEL_W])
                  * pdf_pkg::HP_W'(mag);
        lp_next = pdf_pkg::LP_W'(coeff[pdf_pkg::VEL_W-1:0]) * pdf_pkg::LP_W'(mag);
    end

    always_comb
    begin
        big_next = |hp_reg[pdf_pkg::HP_W-1:HI_W];
        mag_next = pdf_pkg::MAG_W'({hp_reg[HI_W-1:0], {pdf_pkg::FRAC_W{1'b0}}})
                   + pdf_pkg::MAG_W'(lp_reg[pdf_pkg::LP_W-1:pdf_pkg::FRAC_W]);
    end

    // a positive velocity gives a negative force, which may reach -2^31
    always_comb
    begin
        limit      = neg_m_reg ? pdf_pkg::MAG_W'(32'h7fff_ffff)
                               : pdf_pkg::MAG_W'(32'h8000_0000);
        clip       = big_reg || (mag_reg > limit);
        clipped    = clip ? limit[pdf_pkg::VEL_W-1:0] : mag_reg[pdf_pkg::VEL_W-1:0];
        force_next = neg_m_reg ? clipped : (~clipped + 1'b1);
        sat_next   = clip;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_prod)
        begin
            hp_reg    <= hp_next;
            lp_reg    <= lp_next;
            neg_p_reg <= neg;
        end
        if (ctl.ld_mag)
        begin
            mag_reg   <= mag_next;
            big_reg   <= big_next;
            neg_m_reg <= neg_p_reg;
        end
        if (ctl.ld_out)
        begin
            force_reg <= force_next;
            sat_reg   <= sat_next;
        end
    end

    assign force_val = force_reg;
    assign sat       = sat_reg;

endmodule

`default_nettype wire

### hw/rtl/particle_drag_force.sv
// top level of the particle drag force pipeline with its register port
// a result passes the abs, square, sum, square root, k2 product, coefficient, product, magnitude and output stages
// throughput: one velocity per cycle while the output side takes results; the 16-stage square root sets the depth
// each stage holds its item while the next is full, bubbles close up
// reset clears all valid bits and both coefficients to zero
`default_nettype none

module particle_drag_force (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pdf_pkg::ADDR_W-1:0]        paddr,
    input  logic [pdf_pkg::DATA_W-1:0]        pwdata,
    output logic [pdf_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,

    input  logic                              vel_valid,
    output logic                              vel_ready,
    input  logic signed [pdf_pkg::VEL_W-1:0]  vel_x,
    input  logic signed [pdf_pkg::VEL_W-1:0]  vel_y,
    input  logic signed [pdf_pkg::VEL_W-1:0]  vel_z,

    output logic                              force_valid,
    input  logic                              force_ready,
    output logic signed [pdf_pkg::VEL_W-1:0]  force_x,
    output logic signed [pdf_pkg::VEL_W-1:0]  force_y,
    output logic signed [pdf_pkg::VEL_W-1:0]  force_z,
    output logic                              saturated
);

    localparam int NS    = pdf_pkg::NUM_STAGES;
    localparam int LANES = pdf_pkg::LANES;

    // coefficient registers
    logic [pdf_pkg::COEF_W-1:0] lin_reg, lin_next;
    logic [pdf_pkg::COEF_W-1:0] quad_reg, quad_next;
    logic                       wr_en;

    // pipeline control
    logic [NS-1:0] valid_reg, valid_next;
    logic [NS:0]   stage_rdy;

    // payload
    pdf_pkg::vel_item_t item_reg [pdf_pkg::ST_COEFF+1];
    pdf_pkg::vel_item_t item_next;
    logic [pdf_pkg::SQ_W-1:0]    sq_reg [LANES];
    logic [pdf_pkg::SUM_W-1:0]   sum_reg, sum_next;
    pdf_pkg::root_state_t        root_in  [pdf_pkg::SQRT_STAGES];
    pdf_pkg::root_state_t        root_out [pdf_pkg::SQRT_STAGES];
    logic [pdf_pkg::ROOT_W-1:0]  speed;
    logic [pdf_pkg::QPROD_W-1:0] qprod_reg, qprod_next;
    logic [pdf_pkg::CEFF_W-1:0]  coeff_reg, coeff_next;
    pdf_pkg::comp_ctl_t          comp_ctl;
    logic [LANES-1:0][pdf_pkg::VEL_W-1:0] force_lane;
    logic [LANES-1:0]                     sat_lane;
    logic [LANES-1:0][pdf_pkg::VEL_W-1:0] vel_lane;

    // register port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        lin_next  = lin_reg;
        quad_next = quad_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                pdf_pkg::REG_LINEAR:    lin_next  = pwdata[pdf_pkg::COEF_W-1:0];
                pdf_pkg::REG_QUADRATIC: quad_next = pwdata[pdf_pkg::COEF_W-1:0];
                default:                lin_next  = lin_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            pdf_pkg::REG_LINEAR:    prdata = {1'b0, lin_reg};
            pdf_pkg::REG_QUADRATIC: prdata = {1'b0, quad_reg};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_reg  <= '0;
            quad_reg <= '0;
        end
        else
        begin
            lin_reg  <= lin_next;
            quad_reg <= quad_next;
        end
    end

    // stage handshake: a stage loads when empty or when its successor moves on
    assign stage_rdy[NS] = force_ready;

    generate
        for (genvar s = 0; s < NS; s++)
        begin : g_rdy
            assign stage_rdy[s] = !valid_reg[s] || stage_rdy[s+1];
        end
    endgenerate

    assign vel_ready = stage_rdy[0];

    always_comb
    begin
        valid_next[0] = stage_rdy[0] ? vel_valid : valid_reg[0];
        for (int s = 1; s < NS; s++)
        begin
            valid_next[s] = stage_rdy[s] ? valid_reg[s-1] : valid_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // magnitude and sign
    assign vel_lane[0] = vel_x;
    assign vel_lane[1] = vel_y;
    assign vel_lane[2] = vel_z;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            item_next.neg[l] = vel_lane[l][pdf_pkg::VEL_W-1];
            item_next.mag[l] = item_next.neg[l] ? (~vel_lane[l] + 1'b1) : vel_lane[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[pdf_pkg::ST_ABS])
        begin
            item_reg[0] <= item_next;
        end
    end

    generate
        for (genvar k = 1; k <= pdf_pkg::ST_COEFF; k++)
        begin : g_item
            always_ff @(posedge clk)
            begin
                if (stage_rdy[k])
                begin
                    item_reg[k] <= item_reg[k-1];
                end
            end
        end
    endgenerate

    // squares
    generate
        for (genvar l = 0; l < LANES; l++)
        begin : g_sq
            always_ff @(posedge clk)
            begin
                if (stage_rdy[pdf_pkg::ST_SQ])
                begin
                    sq_reg[l] <= pdf_pkg::SQ_W'(item_reg[pdf_pkg::ST_ABS].mag[l])
                                 * pdf_pkg::SQ_W'(item_reg[pdf_pkg::ST_ABS].mag[l]);
                end
            end
        end
    endgenerate

    // sum of squares, below 2^64
    assign sum_next = pdf_pkg::SUM_W'(sq_reg[0]) + pdf_pkg::SUM_W'(sq_reg[1])
                      + pdf_pkg::SUM_W'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        if (stage_rdy[pdf_pkg::ST_SUM])
        begin
            sum_reg <= sum_next;
        end
    end

    // square root
    assign root_in[0] = '{rad: sum_reg, rem: '0, root: '0};

    generate
        for (genvar r = 0; r < pdf_pkg::SQRT_STAGES; r++)
        begin : g_root
            if (r > 0)
            begin : g_link
                assign root_in[r] = root_out[r-1];
            end
            pdf_root_stage u_root (
                .clk  (clk),
                .load (stage_rdy[pdf_pkg::ST_ROOT0 + r]),
                .din  (root_in[r]),
                .dout (root_out[r])
            );
        end
    endgenerate

    assign speed = root_out[pdf_pkg::SQRT_STAGES-1].root;

    // coefficient k1 + k2 * speed
    assign qprod_next = pdf_pkg::QPROD_W'(quad_reg) * pdf_pkg::QPROD_W'(speed);
    assign coeff_next = pdf_pkg::CEFF_W'(lin_reg)
                        + pdf_pkg::CEFF_W'(qprod_reg[pdf_pkg::QPROD_W-1:pdf_pkg::FRAC_W]);

    always_ff @(posedge clk)
    begin
        if (stage_rdy[pdf_pkg::ST_QPROD])
        begin
            qprod_reg <= qprod_next;
        end
        if (stage_rdy[pdf_pkg::ST_COEFF])
        begin
            coeff_reg <= coeff_next;
        end
    end

    // force components
    assign comp_ctl = '{ld_prod: stage_rdy[pdf_pkg::ST_PROD],
                        ld_mag:  stage_rdy[pdf_pkg::ST_MAG],
                        ld_out:  stage_rdy[pdf_pkg::ST_OUT]};

    generate
        for (genvar l = 0; l < LANES; l++)
        begin : g_comp
            pdf_drag_comp u_comp (
                .clk       (clk),
                .ctl       (comp_ctl),
                .coeff     (coeff_reg),
                .mag       (item_reg[pdf_pkg::ST_COEFF].mag[l]),
                .neg       (item_reg[pdf_pkg::ST_COEFF].neg[l]),
                .force_val (force_lane[l]),
                .sat       (sat_lane[l])
            );
        end
    endgenerate

    assign force_valid = valid_reg[pdf_pkg::ST_OUT];
    assign force_x     = force_lane[0];
    assign force_y     = force_lane[1];
    assign force_z     = force_lane[2];
    assign saturated   = |sat_lane;

`ifndef SYNTH
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        vel_valid && vel_ready |=> valid_reg[pdf_pkg::ST_ABS])
        else $error("accepted transfer did not reach the first stage");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!force_valid || force_ready) |-> vel_ready)
        else $error("input stalled while the output side was free");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[pdf_pkg::ST_SUM] && !stage_rdy[pdf_pkg::ST_SUM + 1]
        |=> valid_reg[pdf_pkg::ST_SUM] && $stable(sum_reg))
        else $error("stalled stage lost or changed its item");

    a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[pdf_pkg::ST_QPROD - 1]
        |-> root_out[pdf_pkg::SQRT_STAGES-1].rem <= pdf_pkg::REM_W'({speed, 1'b0}))
        else $error("square root remainder out of range");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        force_valid && saturated
        |-> (force_x == 32'h7fff_ffff || force_x == 32'h8000_0000
             || force_y == 32'h7fff_ffff || force_y == 32'h8000_0000
             || force_z == 32'h7fff_ffff || force_z == 32'h8000_0000))
        else $error("saturated flag without a clipped component");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking testbench for the particle drag force pipeline
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int PHASE_ITEMS     = 85;
    localparam int NUM_PHASES      = 8;

    localparam logic [pdf_pkg::VEL_W-1:0] VEL_MAX = 32'h7fff_ffff;
    localparam logic [pdf_pkg::VEL_W-1:0] VEL_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [pdf_pkg::VEL_W-1:0] fx;
        logic [pdf_pkg::VEL_W-1:0] fy;
        logic [pdf_pkg::VEL_W-1:0] fz;
        logic                      clipped;
    } drag_force_t;

    class drag_scoreboard;
        logic [pdf_pkg::COEF_W-1:0] k_linear;
        logic [pdf_pkg::COEF_W-1:0] k_quadratic;
        drag_force_t                expected_forces[$];
        int                         failures;

        function new();
            k_linear    = '0;
            k_quadratic = '0;
            failures    = 0;
        endfunction

        function void set_coefficient(input logic index,
                                      input logic [pdf_pkg::DATA_W-1:0] value);
            if (index == pdf_pkg::REG_LINEAR)
                k_linear = value[pdf_pkg::COEF_W-1:0];
            else
                k_quadratic = value[pdf_pkg::COEF_W-1:0];
        endfunction

        function logic [pdf_pkg::VEL_W:0] magnitude(input logic [pdf_pkg::VEL_W-1:0] v);
            logic [pdf_pkg::VEL_W:0] ext;
            ext = {v[pdf_pkg::VEL_W-1], v};
            return v[pdf_pkg::VEL_W-1] ? ~ext + 1'b1 : ext;
        endfunction

        function logic [31:0] speed_of(input logic [63:0] radicand);
            logic [31:0] root;
            logic [31:0] trial;
            root = '0;
            for (int i = 31; i >= 0; i--)
            begin
                trial = root | (32'd1 << i);
                if (64'(trial) * 64'(trial) <= radicand)
                    root = trial;
            end
            return root;
        endfunction

        function logic [pdf_pkg::VEL_W-1:0] drag_term(input logic [63:0] coeff,
                                                       input logic [pdf_pkg::VEL_W-1:0] v,
                                                       inout logic clipped);
            logic [pdf_pkg::VEL_W:0] av;
            logic [127:0]            mag;
            logic [127:0]            limit;
            av    = magnitude(v);
            mag   = (128'(coeff) * 128'(av)) >> pdf_pkg::FRAC_W;
            limit = v[pdf_pkg::VEL_W-1] ? 128'h7fff_ffff : 128'h8000_0000;
            if (mag > limit)
            begin
                clipped = 1'b1;
                mag     = limit;
            end
            return v[pdf_pkg::VEL_W-1] ? mag[pdf_pkg::VEL_W-1:0]
                                       : 32'd0 - mag[pdf_pkg::VEL_W-1:0];
        endfunction

        function void note_velocity(input logic [pdf_pkg::VEL_W-1:0] vx,
                                    input logic [pdf_pkg::VEL_W-1:0] vy,
                                    input logic [pdf_pkg::VEL_W-1:0] vz);
            logic [pdf_pkg::VEL_W:0] ax;
            logic [pdf_pkg::VEL_W:0] ay;
            logic [pdf_pkg::VEL_W:0] az;
            logic [63:0]             sum_sq;
            logic [63:0]             speed;
            logic [63:0]             coeff;
            logic                    clip;
            drag_force_t             f;
            ax     = magnitude(vx);
            ay     = magnitude(vy);
            az     = magnitude(vz);
            sum_sq = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay) + 64'(az) * 64'(az);
            speed  = 64'(speed_of(sum_sq));
            coeff  = 64'(k_linear) + ((64'(k_quadratic) * speed) >> pdf_pkg::FRAC_W);
            clip   = 1'b0;
            f.fx   = drag_term(coeff, vx, clip);
            f.fy   = drag_term(coeff, vy, clip);
            f.fz   = drag_term(coeff, vz, clip);
            f.clipped = clip;
            expected_forces = {expected_forces, f};
        endfunction

        function void check_force(input logic [pdf_pkg::VEL_W-1:0] fx,
                                  input logic [pdf_pkg::VEL_W-1:0] fy,
                                  input logic [pdf_pkg::VEL_W-1:0] fz,
                                  input logic sat);
            drag_force_t want;
            if (expected_forces.size() == 0)
            begin
                $error("force transfer with nothing expected");
                failures++;
                return;
            end
            want = expected_forces.pop_front();
            if (fx !== want.fx)
            begin
                $error("force_x: expected %0d, got %0d", $signed(want.fx), $signed(fx));
                failures++;
            end
            if (fy !== want.fy)
            begin
                $error("force_y: expected %0d, got %0d", $signed(want.fy), $signed(fy));
                failures++;
            end
            if (fz !== want.fz)
            begin
                $error("force_z: expected %0d, got %0d", $signed(want.fz), $signed(fz));
                failures++;
            end
            if (sat !== want.clipped)
            begin
                $error("saturated: expected %0b, got %0b", want.clipped, sat);
                failures++;
            end
        endfunction

        function int pending();
            return expected_forces.size();
        endfunction
    endclass

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             psel        = 1'b0;
    logic                             penable     = 1'b0;
    logic                             pwrite      = 1'b0;
    logic [pdf_pkg::ADDR_W-1:0]       paddr       = '0;
    logic [pdf_pkg::DATA_W-1:0]       pwdata      = '0;
    logic [pdf_pkg::DATA_W-1:0]       prdata;
    logic                             pready;
    logic                             vel_valid   = 1'b0;
    logic                             vel_ready;
    logic signed [pdf_pkg::VEL_W-1:0] vel_x       = '0;
    logic signed [pdf_pkg::VEL_W-1:0] vel_y       = '0;
    logic signed [pdf_pkg::VEL_W-1:0] vel_z       = '0;
    logic                             force_valid;
    logic                             force_ready = 1'b0;
    logic signed [pdf_pkg::VEL_W-1:0] force_x;
    logic signed [pdf_pkg::VEL_W-1:0] force_y;
    logic signed [pdf_pkg::VEL_W-1:0] force_z;
    logic                             saturated;

    drag_scoreboard drag_check = new();
    int velocities_sent   = 0;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int stall_cycles      = 0;
    bit long_hold_done    = 1'b0;

    particle_drag_force dut (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // transfer monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (vel_valid && vel_ready)
                drag_check.note_velocity(vel_x, vel_y, vel_z);
            if (force_valid && force_ready)
                drag_check.check_force(force_x, force_y, force_z, saturated);
            if ((vel_valid && vel_ready) || (force_valid && force_ready) || psel)
                stall_cycles = 0;
            else if (stall_cycles == STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                stall_cycles = stall_cycles + 1;
        end
    end

    // result side back-pressure
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (velocities_sent >= 120 && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                force_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
                force_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic send_velocity(input logic [pdf_pkg::VEL_W-1:0] vx,
                                 input logic [pdf_pkg::VEL_W-1:0] vy,
                                 input logic [pdf_pkg::VEL_W-1:0] vz);
        if (velocities_sent < 233)
        begin
            sender_idle_pct   = 6;
            receiver_idle_pct = 78;
        end
        else if (velocities_sent < 466)
        begin
            sender_idle_pct   = 78;
            receiver_idle_pct = 6;
        end
        else
        begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
        end
        while ($urandom_range(99) < sender_idle_pct)
        begin
            vel_valid <= 1'b0;
            @(posedge clk);
        end
        vel_valid <= 1'b1;
        vel_x     <= vx;
        vel_y     <= vy;
        vel_z     <= vz;
        @(posedge clk);
        while (!vel_ready) @(posedge clk);
        velocities_sent++;
    endtask

    task automatic wait_for_results();
        vel_valid <= 1'b0;
        @(posedge clk);
        while (drag_check.pending() != 0) @(posedge clk);
    endtask

    task automatic write_register(input logic index,
                                  input logic [pdf_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= pdf_pkg::ADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        drag_check.set_coefficient(index, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_drag(input logic [pdf_pkg::DATA_W-1:0] k1,
                            input logic [pdf_pkg::DATA_W-1:0] k2);
        write_register(pdf_pkg::REG_LINEAR, k1);
        write_register(pdf_pkg::REG_QUADRATIC, k2);
    endtask

    function automatic logic [pdf_pkg::VEL_W-1:0] random_velocity();
        logic [pdf_pkg::VEL_W-1:0] raw;
        raw = $urandom();
        unique case ($urandom_range(9))
            0:
                unique case ($urandom_range(4))
                    0:       return '0;
                    1:       return 32'd1;
                    2:       return '1;
                    3:       return VEL_MAX;
                    default: return VEL_MIN;
                endcase
            1, 2, 3: return raw;
            default: return $signed(raw) >>> $urandom_range(31);
        endcase
    endfunction

    initial
    begin
        logic [pdf_pkg::DATA_W-1:0] k1;
        logic [pdf_pkg::DATA_W-1:0] k2;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coefficients still at their reset value
        send_velocity(VEL_MAX, VEL_MIN, 32'h1234_5678);
        send_velocity('0, '0, '0);
        wait_for_results();

        // pure linear drag of two, right at the clipping edges
        set_drag(32'h0002_0000, 32'h0);
        send_velocity('0, '0, '0);
        send_velocity(32'h4000_0000, '0, '0);
        send_velocity(32'h4000_0001, '0, '0);
        send_velocity(-32'sh4000_0000, '0, '0);
        send_velocity(-32'sh3fff_ffff, '0, '0);
        send_velocity(VEL_MIN, VEL_MIN, VEL_MIN);
        send_velocity(VEL_MAX, VEL_MAX, VEL_MAX);
        send_velocity(32'd1, '1, '0);
        wait_for_results();

        // upper bits of the written value are dropped
        set_drag(32'h8001_0000, 32'h8000_8000);
        send_velocity('0, '0, '0);
        send_velocity(32'h0001_0000, '0, '0);
        send_velocity('0, -32'sh0001_0000, '0);
        send_velocity('0, '0, 32'h0003_0000);
        send_velocity(32'h0003_0000, 32'h0004_0000, '0);
        send_velocity(VEL_MAX, VEL_MIN, 32'd1);
        send_velocity('1, '1, '1);
        send_velocity(32'h0000_7fff, -32'sh0000_8000, 32'h0000_1234);
        send_velocity(32'h00ff_ff00, -32'sh0100_0000, 32'h00aa_aa00);
        wait_for_results();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            unique case (p)
                0:       begin k1 = 32'h0001_0000; k2 = 32'h0000_0100; end
                1:       begin k1 = 32'h0;         k2 = 32'h7fff_ffff; end
                2:       begin k1 = 32'h7fff_ffff; k2 = 32'h0;         end
                3:       begin k1 = 32'hffff_ffff; k2 = 32'hffff_ffff; end
                4:       begin k1 = 32'h0;         k2 = 32'h0;         end
                5:       begin
                             k1 = $urandom() >> $urandom_range(31);
                             k2 = $urandom() >> $urandom_range(31);
                         end
                6:       begin k1 = $urandom();    k2 = $urandom();    end
                default: begin k1 = 32'h0000_4000; k2 = 32'h0000_0010; end
            endcase
            set_drag(k1, k2);
            repeat (PHASE_ITEMS)
                send_velocity(random_velocity(), random_velocity(), random_velocity());
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (drag_check.failures == 0 && drag_check.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### particle_drag_force.f
hw/rtl/pdf_pkg.sv
hw/rtl/pdf_root_stage.sv
hw/rtl/pdf_drag_comp.sv
hw/rtl/particle_drag_force.sv
tb/testbench.sv
